// ===== rtl/cra_pkg.sv =====
// shared constants, types and helpers for the charged row address cache
`default_nettype none

package cra_pkg;

  localparam int unsigned WAYS          = 4;
  localparam int unsigned NUM_SETS      = 16;
  localparam int unsigned ROW_BITS      = 17;
  localparam int unsigned SUBARRAY_BITS = 6;

  localparam int unsigned CAPACITY = NUM_SETS * WAYS;
  localparam int unsigned TAG_W    = ROW_BITS + SUBARRAY_BITS;
  localparam int unsigned SA_W     = (SUBARRAY_BITS > 0) ? SUBARRAY_BITS : 1;
  localparam int unsigned SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned AGE_W    = WAY_W;
  localparam int unsigned FUNC_W   = 2;

  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

  // set index: a mask for a power-of-two set count, else a reciprocal multiply
  localparam bit SETS_POW2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);
  localparam int unsigned RECIP_SHIFT = TAG_W + SET_W;
  localparam int unsigned RECIP_W     = TAG_W + 1;
  localparam int unsigned PROD_W      = TAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS));
  localparam logic [SET_W-1:0] SETS_LOW = SET_W'(NUM_SETS);
  localparam logic [TAG_W-1:0] SET_MASK = TAG_W'(NUM_SETS - 1);
  localparam logic [TAG_W-1:0] SA_MASK  = TAG_W'((64'd1 << SUBARRAY_BITS) - 64'd1);

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_INVAL  = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } way_entry_t;

  typedef way_entry_t [WAYS-1:0] set_row_t;

  typedef struct packed {
    logic             hit;
    logic             inserted;
    logic             evicted;
    logic             row_we;
    logic             fill_we;
    logic [WAY_W-1:0] fill_way;
    set_row_t         row;
  } way_result_t;

  typedef struct packed {
    logic             row_we;
    logic [SET_W-1:0] set;
    set_row_t         row;
    logic             fill_we;
    logic [WAY_W-1:0] fill_way;
    logic             clr_we;
    logic [SET_W-1:0] clr_set;
    logic [WAY_W-1:0] clr_way;
  } store_wr_t;

  function automatic logic [TAG_W-1:0] make_tag(logic [ROW_BITS-1:0] row,
                                                logic [SA_W-1:0] sa);
    logic [TAG_W-1:0] r;
    logic [TAG_W-1:0] s;
    r = TAG_W'(row) << SUBARRAY_BITS;
    s = TAG_W'(sa) & SA_MASK;
    return r | s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cra_set_store.sv =====
// row memory of tags and ages per set, plus the valid flags in flops
`default_nettype none

module cra_set_store (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      rd_en_i,
  input  wire logic [cra_pkg::SET_W-1:0] rd_set_i,
  input  wire logic [cra_pkg::SET_W-1:0] cur_set_i,
  input  wire cra_pkg::store_wr_t        wr_i,
  output cra_pkg::set_row_t              rd_row_o,
  output logic [cra_pkg::WAYS-1:0]       valid_row_o
);

  cra_pkg::set_row_t         mem_q [cra_pkg::NUM_SETS];
  cra_pkg::set_row_t         rd_row_q;
  logic [cra_pkg::WAYS-1:0]  valid_q [cra_pkg::NUM_SETS];

  always_ff @(posedge clk_i) begin
    if (wr_i.row_we) begin
      mem_q[wr_i.set] <= wr_i.row;
    end
    if (rd_en_i) begin
      rd_row_q <= mem_q[rd_set_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < int'(cra_pkg::NUM_SETS); s++) begin
        valid_q[s] <= '0;
      end
    end else begin
      if (wr_i.fill_we) begin
        valid_q[wr_i.set][wr_i.fill_way] <= 1'b1;
      end
      if (wr_i.clr_we) begin
        valid_q[wr_i.clr_set][wr_i.clr_way] <= 1'b0;
      end
    end
  end

  assign rd_row_o    = rd_row_q;
  assign valid_row_o = valid_q[cur_set_i];

endmodule

`default_nettype wire

// ===== rtl/cra_way_logic.sv =====
// tag match, victim choice and age update for one set row
`default_nettype none

module cra_way_logic (
  input  wire logic [cra_pkg::FUNC_W-1:0] func_i,
  input  wire logic [cra_pkg::TAG_W-1:0]  tag_i,
  input  wire cra_pkg::set_row_t          row_i,
  input  wire logic [cra_pkg::WAYS-1:0]   valid_i,
  output cra_pkg::way_result_t            res_o
);

  logic                      hit_any;
  logic [cra_pkg::WAY_W-1:0] hit_way;
  logic                      inv_any;
  logic [cra_pkg::WAY_W-1:0] inv_way;
  logic [cra_pkg::WAY_W-1:0] vic_way;
  logic [cra_pkg::AGE_W-1:0] min_age;
  logic [cra_pkg::WAY_W-1:0] new_way;

  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    inv_any = 1'b0;
    inv_way = '0;
    vic_way = '0;
    min_age = row_i[0].age;
    for (int w = 0; w < int'(cra_pkg::WAYS); w++) begin
      if (!hit_any && valid_i[w] && (row_i[w].tag == tag_i)) begin
        hit_any = 1'b1;
        hit_way = cra_pkg::WAY_W'(w);
      end
      if (!inv_any && !valid_i[w]) begin
        inv_any = 1'b1;
        inv_way = cra_pkg::WAY_W'(w);
      end
    end
    // strict compare keeps the lowest way on a tie
    for (int w = 1; w < int'(cra_pkg::WAYS); w++) begin
      if (row_i[w].age < min_age) begin
        min_age = row_i[w].age;
        vic_way = cra_pkg::WAY_W'(w);
      end
    end
  end

  assign new_way = inv_any ? inv_way : vic_way;

  always_comb begin
    res_o     = '0;
    res_o.row = row_i;
    case (func_i)
      cra_pkg::FUNC_LOOKUP: begin
        if (hit_any) begin
          res_o.hit    = 1'b1;
          res_o.row_we = 1'b1;
          for (int w = 0; w < int'(cra_pkg::WAYS); w++) begin
            if (valid_i[w] && (row_i[w].age != '0)) begin
              res_o.row[w].age = row_i[w].age - cra_pkg::AGE_W'(1);
            end
          end
          res_o.row[hit_way].age = cra_pkg::AGE_MAX;
        end
      end
      cra_pkg::FUNC_UPDATE: begin
        if (!hit_any) begin
          res_o.inserted         = 1'b1;
          res_o.evicted          = !inv_any;
          res_o.row_we           = 1'b1;
          res_o.fill_we          = 1'b1;
          res_o.fill_way         = new_way;
          res_o.row[new_way].tag = tag_i;
          res_o.row[new_way].age = cra_pkg::AGE_MAX;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/charged_row_address_cache.sv =====
// top level: request handshake, set indexing, invalidate pointer and result register
//
//  channel  | direction | signals                                        | fires on
//  ---------+-----------+------------------------------------------------+--------------------
//  request  | in        | func_i, row_address_i, subarray_index_i        | in_valid & in_ready
//  result   | out       | hit_o, inserted_o, evicted_o                   | out_valid & out_ready
//
//  a request with a power-of-two set count passes a row read, then a modify and
//  write-back step; otherwise a step for the set index product comes first;
//  the steps follow from the single read/modify/write pass over the set row memory.
//  reset clears the valid flags and the invalidate pointer at once, no clearing pass.
//  a result waits in the output register; the write-back step holds while it is untaken.
`default_nettype none

module charged_row_address_cache (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [cra_pkg::FUNC_W-1:0]   func_i,
  input  wire logic [cra_pkg::ROW_BITS-1:0] row_address_i,
  input  wire logic [cra_pkg::SA_W-1:0]     subarray_index_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              hit_o,
  output logic                              inserted_o,
  output logic                              evicted_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_ACCESS = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [cra_pkg::FUNC_W-1:0]  func_q;
  logic [cra_pkg::TAG_W-1:0]   tag_q;
  logic [cra_pkg::TAG_W-1:0]   tag_in;
  logic [cra_pkg::SET_W-1:0]   set_q;
  logic [cra_pkg::SET_W-1:0]   set_idx;
  logic                        set_ready;
  logic [cra_pkg::SET_W-1:0]   inv_set_q, inv_set_d;
  logic [cra_pkg::WAY_W-1:0]   inv_way_q, inv_way_d;
  logic                        out_valid_q, hit_q, inserted_q, evicted_q;
  logic                        in_fire, out_free, commit;

  cra_pkg::set_row_t           rd_row;
  logic [cra_pkg::WAYS-1:0]    valid_row;
  cra_pkg::way_result_t        res;
  cra_pkg::store_wr_t          wr;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign commit     = (state_q == ST_ACCESS) && out_free;
  assign tag_in     = cra_pkg::make_tag(row_address_i, subarray_index_i);

  if (cra_pkg::SETS_POW2) begin : g_mask
    assign set_ready = in_fire;
    assign set_idx   = cra_pkg::SET_W'(tag_in & cra_pkg::SET_MASK);
  end else begin : g_recip
    logic [cra_pkg::PROD_W-1:0] prod_q;
    logic [cra_pkg::SET_W-1:0]  q_lo;
    logic [cra_pkg::SET_W-1:0]  qn;

    always_ff @(posedge clk_i) begin
      if (in_fire) begin
        prod_q <= cra_pkg::PROD_W'(tag_in) * cra_pkg::PROD_W'(cra_pkg::RECIP);
      end
    end

    // only the low bits of quotient times set count matter, the remainder is below it
    assign q_lo      = prod_q[cra_pkg::RECIP_SHIFT +: cra_pkg::SET_W];
    assign qn        = q_lo * cra_pkg::SETS_LOW;
    assign set_ready = (state_q == ST_DIV);
    assign set_idx   = tag_q[cra_pkg::SET_W-1:0] - qn;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = cra_pkg::SETS_POW2 ? ST_ACCESS : ST_DIV;
        end
      end
      ST_DIV: begin
        state_d = ST_ACCESS;
      end
      ST_ACCESS: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // round-robin invalidate pointer kept as set and way
  always_comb begin
    inv_set_d = inv_set_q;
    inv_way_d = inv_way_q;
    if (commit && (func_q == cra_pkg::FUNC_INVAL)) begin
      if (inv_way_q == cra_pkg::WAY_W'(cra_pkg::WAYS - 1)) begin
        inv_way_d = '0;
        if (inv_set_q == cra_pkg::SET_W'(cra_pkg::NUM_SETS - 1)) begin
          inv_set_d = '0;
        end else begin
          inv_set_d = inv_set_q + cra_pkg::SET_W'(1);
        end
      end else begin
        inv_way_d = inv_way_q + cra_pkg::WAY_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      inv_set_q   <= '0;
      inv_way_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      inv_set_q <= inv_set_d;
      inv_way_q <= inv_way_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= func_i;
      tag_q  <= tag_in;
    end
    if (set_ready) begin
      set_q <= set_idx;
    end
    if (commit) begin
      hit_q      <= res.hit;
      inserted_q <= res.inserted;
      evicted_q  <= res.evicted;
    end
  end

  always_comb begin
    wr          = '0;
    wr.set      = set_q;
    wr.row      = res.row;
    wr.fill_way = res.fill_way;
    wr.clr_set  = inv_set_q;
    wr.clr_way  = inv_way_q;
    wr.row_we   = commit && res.row_we;
    wr.fill_we  = commit && res.fill_we;
    wr.clr_we   = commit && (func_q == cra_pkg::FUNC_INVAL);
  end

  cra_set_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (set_ready),
    .rd_set_i    (set_idx),
    .cur_set_i   (set_q),
    .wr_i        (wr),
    .rd_row_o    (rd_row),
    .valid_row_o (valid_row)
  );

  cra_way_logic u_ways (
    .func_i  (func_q),
    .tag_i   (tag_q),
    .row_i   (rd_row),
    .valid_i (valid_row),
    .res_o   (res)
  );

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign inserted_o  = inserted_q;
  assign evicted_o   = evicted_q;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_result_from_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_ACCESS)
    else $error("result raised outside the write-back step");

  a_evict_needs_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && evicted_o) |-> inserted_o)
    else $error("eviction flagged without an insert");

  a_hit_not_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && inserted_o))
    else $error("hit and insert flagged together");

  a_no_write_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACCESS && out_valid_o && !out_ready_i) |-> !(wr.row_we || wr.clr_we))
    else $error("set written while the previous result is untaken");

endmodule

`default_nettype wire
